// ===== src/xmkb_pkg.sv =====
// xmkb_pkg: shared types and constants of the xor-metric k-bucket table
// holds payload structs, operation and status codes, and the 16-bit zero count
// no dependencies
package xmkb_pkg;

  localparam int ID_W        = 128;
  localparam int NUM_BUCKETS = 128;
  localparam int BKT_W       = 7;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_FIND   = 2'd2,
    FN_UNDEF  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic {
    CFG_OWN_HI = 1'b0,
    CFG_OWN_LO = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] node_id_hi;
    logic [63:0] node_id_lo;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [31:0] now;
    logic [4:0]  max_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        updated;
    logic [63:0] out_id_hi;
    logic [63:0] out_id_lo;
    logic [31:0] out_ip;
    logic [15:0] out_port;
    logic [31:0] out_last_seen;
    logic [11:0] node_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] seen;
  } entry_t;

  // leading zeros of a 16-bit chunk, 16 when all zero
  function automatic logic [4:0] lz16(input logic [15:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd16;
    hit = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(15 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== src/xor_metric_kbucket_table.sv =====
// xor_metric_kbucket_table: 128-bit xor-metric routing table with k-buckets
// entries in one synchronous memory, bucket fill counts in a second one
// depends on xmkb_pkg
//
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall | xmkb_pkg::in_item_t, one operation
// out_    | output    | out_valid/out_stall | xmkb_pkg::out_item_t, one or more per item
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index selects own id half, cfg_data
//
// one item at a time; the bucket index comes from a 16-bit zero scan, and entry reads are
// registered through the entry memory port (a read state, then a compare state)
// add / remove: the bucket is scanned entry by entry, remove then reads and rewrites each shifted entry
// find: per visited bucket a fill read plus a full bucket scan per returned entry (selection
// rescans the bucket), and a pass through the fill check per skipped bucket position
// synchronous active-low reset clears control, own id, total and fill valid bits
// the entry memory holds no reset; slots at or above a bucket's fill are never read
module xor_metric_kbucket_table #(
  parameter int BUCKET_DEPTH = 16,
  parameter int MAX_REPLY    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  xmkb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output xmkb_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data
);
  import xmkb_pkg::*;

  localparam int SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int TOT_W  = $clog2(SLOTS + 1);
  localparam int K_W    = $clog2(MAX_REPLY + 1);

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_LZC    = 15'h0002,
    S_DISP   = 15'h0004,
    S_FILL   = 15'h0008,
    S_RD     = 15'h0010,
    S_CMP    = 15'h0020,
    S_APPEND = 15'h0040,
    S_SHRD   = 15'h0080,
    S_SHWR   = 15'h0100,
    S_RMDONE = 15'h0200,
    S_REPLY  = 15'h0400,
    S_BFILL  = 15'h0800,
    S_BGOT   = 15'h1000,
    S_FRD    = 15'h2000,
    S_FCMP   = 15'h4000
  } state_t;

  // find emit and flush share the select path, kept as separate flags
  state_t state_r;
  logic   emit_r;
  logic   flush_r;

  // configuration
  logic [63:0] own_hi_r, own_lo_r;

  // latched item and search state
  in_item_t            item_r;
  logic [ID_W-1:0]     xor_r;
  logic [2:0]          chunk_r;
  logic [BKT_W-1:0]    bucket_r;
  logic [BKT_W-1:0]    tb_r;
  logic [BKT_W:0]      d_r;
  logic                side_r;
  logic [SLOT_W-1:0]   base_r, slot_r;
  logic [FILL_W-1:0]   n_r, idx_r, e_r;
  logic [K_W-1:0]      want_r, k_r;
  logic [1:0]          res_status_r;
  logic                res_upd_r;
  logic [TOT_W-1:0]    tot_r;
  logic [ID_W-1:0]     prev_r, best_r;
  logic                have_prev_r, have_best_r;
  entry_t              best_ent_r, held_r;
  logic                held_vld_r;

  // entry memory and fill memory
  entry_t            ent_mem [SLOTS];
  entry_t            ent_rd_r;
  logic              ent_we;
  logic [SLOT_W-1:0] ent_waddr;
  entry_t            ent_wdata;

  logic [FILL_W-1:0] fill_mem [NUM_BUCKETS];
  logic [FILL_W-1:0] fill_rd_r;
  logic              fill_rv_r;
  logic [NUM_BUCKETS-1:0] fill_vld_r;
  logic              fill_we;
  logic [FILL_W-1:0] fill_wdata;
  logic [FILL_W-1:0] fill_cur;

  // output register
  out_item_t out_r;
  logic      out_valid_r;
  logic      out_free;
  logic      push;
  out_item_t push_item;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign fill_cur  = fill_rv_r ? fill_rd_r : '0;

  // bucket index from the scanned chunk, clamped to the last bucket
  logic [4:0]       lz;
  logic [7:0]       lz_sum;
  logic [BKT_W-1:0] lz_bkt;
  assign lz     = lz16(xor_r[ID_W-1 -: 16]);
  assign lz_sum = {2'b00, chunk_r, 3'b000} + {2'b00, chunk_r, 3'b000} + 8'(lz);
  assign lz_bkt = (lz_sum > 8'(NUM_BUCKETS - 1)) ? BKT_W'(NUM_BUCKETS - 1) : lz_sum[BKT_W-1:0];

  logic [SLOT_W-1:0] bucket_base;
  assign bucket_base = SLOT_W'(SLOT_W'(bucket_r) * SLOT_W'(BUCKET_DEPTH));

  // entry compare paths
  logic            id_match, own_match;
  logic [ID_W-1:0] xdist;
  logic            cand;
  assign id_match  = (ent_rd_r.id_hi == item_r.node_id_hi) && (ent_rd_r.id_lo == item_r.node_id_lo);
  assign own_match = (item_r.node_id_hi == own_hi_r) && (item_r.node_id_lo == own_lo_r);
  assign xdist     = {ent_rd_r.id_hi, ent_rd_r.id_lo} ^ {item_r.node_id_hi, item_r.node_id_lo};
  assign cand      = (!have_prev_r || xdist > prev_r) && (!have_best_r || xdist < best_r);

  // next neighbor bucket: t, t-1, t+1, t-2, t+2, ...
  logic [BKT_W:0] nd;
  logic           ns;
  logic [BKT_W+1:0] nb_up;
  logic           nb_ok, walk_end;
  logic [BKT_W-1:0] nb;
  always_comb begin
    if (!side_r && d_r != '0) begin
      nd = d_r;
      ns = 1'b1;
    end else begin
      nd = d_r + 1'b1;
      ns = 1'b0;
    end
    walk_end = (nd >= (BKT_W+1)'(NUM_BUCKETS));
    nb_up    = (BKT_W+2)'(tb_r) + (BKT_W+2)'(nd);
    if (ns) begin
      nb_ok = (nb_up < (BKT_W+2)'(NUM_BUCKETS));
      nb    = nb_up[BKT_W-1:0];
    end else begin
      nb_ok = (nd <= (BKT_W+1)'(tb_r));
      nb    = BKT_W'((BKT_W+1)'(tb_r) - nd);
    end
  end

  logic [K_W-1:0] want_in;
  assign want_in = (32'(item_r.max_count) > MAX_REPLY) ? K_W'(MAX_REPLY) : K_W'(item_r.max_count);

  // memory write controls
  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = slot_r;
    ent_wdata  = ent_rd_r;
    fill_we    = 1'b0;
    fill_wdata = n_r;
    case (state_r)
      S_CMP: begin
        // refresh of a present entry
        if (id_match && item_r.func == FN_ADD) begin
          ent_we    = 1'b1;
          ent_wdata = '{id_hi: ent_rd_r.id_hi, id_lo: ent_rd_r.id_lo, ip: item_r.peer_ip,
                        port: item_r.peer_port, seen: item_r.now};
        end
      end
      S_APPEND: begin
        ent_we     = 1'b1;
        ent_waddr  = base_r + SLOT_W'(n_r);
        ent_wdata  = '{id_hi: item_r.node_id_hi, id_lo: item_r.node_id_lo, ip: item_r.peer_ip,
                       port: item_r.peer_port, seen: item_r.now};
        fill_we    = 1'b1;
        fill_wdata = n_r + 1'b1;
      end
      S_SHWR: begin
        // close the gap, one entry down
        ent_we    = 1'b1;
        ent_waddr = slot_r - 1'b1;
      end
      S_RMDONE: begin
        fill_we    = 1'b1;
        fill_wdata = n_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_r <= ent_mem[slot_r];
    if (fill_we) begin
      fill_mem[bucket_r] <= fill_wdata;
    end
    fill_rd_r <= fill_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r <= '0;
      fill_rv_r  <= 1'b0;
    end else begin
      fill_rv_r <= fill_vld_r[bucket_r];
      if (fill_we) begin
        fill_vld_r[bucket_r] <= 1'b1;
      end
    end
  end

  // result pushes
  always_comb begin
    push      = 1'b0;
    push_item = '{status: res_status_r, updated: res_upd_r, out_id_hi: '0, out_id_lo: '0,
                  out_ip: '0, out_port: '0, out_last_seen: '0, node_total: 12'(tot_r),
                  last: 1'b1};
    if (state_r == S_REPLY) begin
      push = out_free;
    end else if (emit_r || flush_r) begin
      push = held_vld_r ? out_free : (flush_r && out_free);
      if (held_vld_r) begin
        push_item = '{status: ST_OK, updated: 1'b0, out_id_hi: held_r.id_hi,
                      out_id_lo: held_r.id_lo, out_ip: held_r.ip, out_port: held_r.port,
                      out_last_seen: held_r.seen, node_total: 12'(tot_r), last: flush_r};
      end else begin
        push_item.status = ST_NOTFOUND;
        push_item.updated = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (push) begin
      out_r <= push_item;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_hi_r <= '0;
      own_lo_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_HI: own_hi_r <= cfg_data;
        CFG_OWN_LO: own_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      emit_r     <= 1'b0;
      flush_r    <= 1'b0;
      tot_r      <= '0;
      held_vld_r <= 1'b0;
    end else if (emit_r) begin
      // hand the previous find result on, keep the new one back
      if (!held_vld_r || out_free) begin
        held_r      <= best_ent_r;
        held_vld_r  <= 1'b1;
        prev_r      <= best_r;
        have_prev_r <= 1'b1;
        k_r         <= k_r + 1'b1;
        e_r         <= e_r + 1'b1;
        emit_r      <= 1'b0;
        idx_r       <= '0;
        slot_r      <= base_r;
        have_best_r <= 1'b0;
        if (k_r + 1'b1 == want_r) begin
          flush_r <= 1'b1;
        end else if (e_r + 1'b1 == n_r) begin
          // walk on to the next bucket
          if (walk_end) begin
            flush_r <= 1'b1;
          end else begin
            d_r    <= nd;
            side_r <= ns;
            if (nb_ok) begin
              bucket_r <= nb;
              state_r  <= S_BFILL;
            end else begin
              state_r <= S_BGOT;
              n_r     <= '0;
            end
          end
        end else begin
          state_r <= S_FRD;
        end
      end
    end else if (flush_r) begin
      if (out_free) begin
        flush_r    <= 1'b0;
        held_vld_r <= 1'b0;
        state_r    <= S_IDLE;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r  <= in_item;
            xor_r   <= {in_item.node_id_hi ^ own_hi_r, in_item.node_id_lo ^ own_lo_r};
            chunk_r <= '0;
            state_r <= S_LZC;
          end
        end
        S_LZC: begin
          // 16 bits of the distance per cycle
          if (xor_r[ID_W-1 -: 16] != '0 || chunk_r == 3'd7) begin
            bucket_r <= lz_bkt;
            tb_r     <= lz_bkt;
            state_r  <= S_DISP;
          end else begin
            xor_r   <= xor_r << 16;
            chunk_r <= chunk_r + 1'b1;
          end
        end
        S_DISP: begin
          res_upd_r <= 1'b0;
          base_r    <= bucket_base;
          case (func_t'(item_r.func))
            FN_ADD: begin
              if (own_match) begin
                res_status_r <= ST_REFUSED;
                state_r      <= S_REPLY;
              end else begin
                state_r <= S_FILL;
              end
            end
            FN_REMOVE: state_r <= S_FILL;
            FN_FIND: begin
              want_r      <= want_in;
              k_r         <= '0;
              d_r         <= '0;
              side_r      <= 1'b0;
              held_vld_r  <= 1'b0;
              if (want_in == '0) begin
                flush_r <= 1'b1;
              end else begin
                state_r <= S_BFILL;
              end
            end
            default: begin
              res_status_r <= ST_REFUSED;
              state_r      <= S_REPLY;
            end
          endcase
        end
        S_FILL: begin
          n_r    <= fill_cur;
          idx_r  <= '0;
          slot_r <= base_r;
          if (fill_cur == '0) begin
            if (item_r.func == FN_ADD) begin
              state_r <= S_APPEND;
            end else begin
              res_status_r <= ST_NOTFOUND;
              state_r      <= S_REPLY;
            end
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (id_match) begin
            if (item_r.func == FN_ADD) begin
              res_status_r <= ST_OK;
              res_upd_r    <= 1'b1;
              state_r      <= S_REPLY;
            end else if (slot_r == base_r + SLOT_W'(n_r) - 1'b1) begin
              state_r <= S_RMDONE;
            end else begin
              slot_r  <= slot_r + 1'b1;
              state_r <= S_SHRD;
            end
          end else if (idx_r + 1'b1 == n_r) begin
            if (item_r.func == FN_ADD) begin
              if (n_r >= FILL_W'(BUCKET_DEPTH)) begin
                res_status_r <= ST_REFUSED;
                state_r      <= S_REPLY;
              end else begin
                state_r <= S_APPEND;
              end
            end else begin
              res_status_r <= ST_NOTFOUND;
              state_r      <= S_REPLY;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            slot_r  <= slot_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_APPEND: begin
          tot_r        <= tot_r + 1'b1;
          res_status_r <= ST_OK;
          state_r      <= S_REPLY;
        end
        S_SHRD: state_r <= S_SHWR;
        S_SHWR: begin
          if (slot_r == base_r + SLOT_W'(n_r) - 1'b1) begin
            state_r <= S_RMDONE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_SHRD;
          end
        end
        S_RMDONE: begin
          tot_r        <= tot_r - 1'b1;
          res_status_r <= ST_OK;
          state_r      <= S_REPLY;
        end
        S_REPLY: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_BFILL: begin
          base_r  <= bucket_base;
          state_r <= S_BGOT;
          n_r     <= '1;
        end
        S_BGOT: begin
          // n_r of zero marks a skipped position, else the fill read is in
          if (n_r == '0 || fill_cur == '0) begin
            if (walk_end) begin
              flush_r <= 1'b1;
            end else begin
              d_r    <= nd;
              side_r <= ns;
              if (nb_ok) begin
                bucket_r <= nb;
                state_r  <= S_BFILL;
              end else begin
                n_r <= '0;
              end
            end
          end else begin
            n_r         <= fill_cur;
            e_r         <= '0;
            idx_r       <= '0;
            slot_r      <= base_r;
            have_prev_r <= 1'b0;
            have_best_r <= 1'b0;
            state_r     <= S_FRD;
          end
        end
        S_FRD: state_r <= S_FCMP;
        S_FCMP: begin
          // select the nearest entry beyond the last one given
          if (cand) begin
            best_r      <= xdist;
            best_ent_r  <= ent_rd_r;
            have_best_r <= 1'b1;
          end
          if (idx_r + 1'b1 == n_r) begin
            emit_r <= 1'b1;
          end else begin
            idx_r   <= idx_r + 1'b1;
            slot_r  <= slot_r + 1'b1;
            state_r <= S_FRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a bucket never reports more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> fill_cur <= FILL_W'(BUCKET_DEPTH))
    else $error("bucket fill above depth");

  // a find never gives more entries than asked for
  a_reply_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> k_r < want_r)
    else $error("find reply count overrun");

  // the final result of an item returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_item.last |=> state_r == S_IDLE)
    else $error("last result without return to idle");

  // the table never holds more entries than slots
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= TOT_W'(SLOTS))
    else $error("node total above slot count");

endmodule

// ===== tb/xor_metric_kbucket_table_tb.sv =====
// xor_metric_kbucket_table_tb: self-checking bench for the xor-metric k-bucket table
// keeps its own routing table, predicts every result item and compares field by field
// depends on xmkb_pkg and xor_metric_kbucket_table
`timescale 1ns / 1ps

module xor_metric_kbucket_table_tb;
  import xmkb_pkg::*;

  localparam int DEPTH = 16;
  localparam int REPLY = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  xor_metric_kbucket_table #(.BUCKET_DEPTH(DEPTH), .MAX_REPLY(REPLY)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the routing table
  logic [127:0] own_id;
  entry_t       tbl [NUM_BUCKETS][DEPTH];
  int           fill [NUM_BUCKETS];
  int           total;

  out_item_t    pending_results[$];
  int           mismatches = 0;
  int           unexpected = 0;
  bit           no_idle = 1'b0;   // long stretch without idling
  bit           rx_idle_off = 1'b0;

  // ids recently added, reused so remove and refresh hit real entries
  logic [127:0] known_ids[$];

  function automatic int bucket_index(logic [127:0] id);
    logic [127:0] d;
    int z;
    d = id ^ own_id;
    z = 0;
    for (int i = 127; i >= 0; i--) begin
      if (d[i]) break;
      z++;
    end
    if (z > NUM_BUCKETS - 1) z = NUM_BUCKETS - 1;
    return z;
  endfunction

  function automatic out_item_t blank_result(logic [1:0] st, logic upd);
    out_item_t r;
    r = '0;
    r.status = st;
    r.updated = upd;
    r.node_total = 12'(total);
    return r;
  endfunction

  // appends one expected result item
  function automatic void queue_result(out_item_t r);
    pending_results = {pending_results, r};
  endfunction

  // updates the shadow table and queues the expected result items
  task automatic predict_table_op(in_item_t it);
    logic [127:0] id;
    int b, s, want, k, n, j;
    entry_t e, ord[DEPTH];
    out_item_t r;
    id = {it.node_id_hi, it.node_id_lo};
    b = bucket_index(id);
    s = -1;
    for (int i = 0; i < fill[b]; i++)
      if ({tbl[b][i].id_hi, tbl[b][i].id_lo} == id) s = i;
    case (it.func)
      FN_ADD: begin
        if (id == own_id) r = blank_result(ST_REFUSED, 1'b0);
        else if (s >= 0) begin
          tbl[b][s].ip = it.peer_ip;
          tbl[b][s].port = it.peer_port;
          tbl[b][s].seen = it.now;
          r = blank_result(ST_OK, 1'b1);
        end else if (fill[b] >= DEPTH) r = blank_result(ST_REFUSED, 1'b0);
        else begin
          tbl[b][fill[b]] = '{it.node_id_hi, it.node_id_lo, it.peer_ip, it.peer_port, it.now};
          fill[b]++;
          total++;
          r = blank_result(ST_OK, 1'b0);
        end
        r.last = 1'b1;
        queue_result(r);
      end
      FN_REMOVE: begin
        if (s >= 0) begin
          for (int i = s; i < fill[b] - 1; i++) tbl[b][i] = tbl[b][i+1];
          fill[b]--;
          total--;
          r = blank_result(ST_OK, 1'b0);
        end else r = blank_result(ST_NOTFOUND, 1'b0);
        r.last = 1'b1;
        queue_result(r);
      end
      FN_UNDEF: begin
        r = blank_result(ST_REFUSED, 1'b0);
        r.last = 1'b1;
        queue_result(r);
      end
      default: begin
        want = it.max_count > REPLY ? REPLY : it.max_count;
        k = 0;
        // target bucket, then alternating neighbors below and above
        for (int d = 0; d < NUM_BUCKETS && k < want; d++) begin
          for (int side = 0; side < 2 && k < want; side++) begin
            int bb;
            bb = side == 0 ? b - d : b + d;
            if (d == 0 && side == 1) continue;
            if (bb < 0 || bb >= NUM_BUCKETS) continue;
            n = fill[bb];
            for (int i = 0; i < n; i++) begin
              j = i;
              while (j > 0 && (({tbl[bb][i].id_hi, tbl[bb][i].id_lo} ^ id) <
                     ({ord[j-1].id_hi, ord[j-1].id_lo} ^ id))) begin
                ord[j] = ord[j-1];
                j--;
              end
              ord[j] = tbl[bb][i];
            end
            for (int i = 0; i < n && k < want; i++) begin
              e = ord[i];
              r = blank_result(ST_OK, 1'b0);
              r.out_id_hi = e.id_hi;
              r.out_id_lo = e.id_lo;
              r.out_ip = e.ip;
              r.out_port = e.port;
              r.out_last_seen = e.seen;
              r.last = (k == want - 1);
              queue_result(r);
              k++;
            end
          end
        end
        if (k == 0) begin
          r = blank_result(ST_NOTFOUND, 1'b0);
          r.last = 1'b1;
          queue_result(r);
        end else begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 12);
  endfunction

  // sends one item, predicting at acceptance; valid drops only while idling or while the bench drains
  task automatic send_op(in_item_t it);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table_op(it);
  endtask

  // result checker: receiver stalls at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected result item %p", out_item);
        end else begin
          out_item_t x;
          x = pending_results.pop_front();
          if (x !== out_item) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", x, out_item);
          end
        end
      end
      out_stall <= !rx_idle_off && ($urandom_range(99) < 12);
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_OWN_HI) own_id[127:64] = v;
    else own_id[63:0] = v;
  endtask

  task automatic set_own_id(logic [127:0] id);
    wait_drained();
    write_reg(CFG_OWN_HI, id[127:64]);
    write_reg(CFG_OWN_LO, id[63:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_op(func_t f, logic [127:0] id, logic [4:0] mc);
    in_item_t it;
    it.func = f;
    it.node_id_hi = id[127:64];
    it.node_id_lo = id[63:0];
    it.peer_ip = $urandom;
    it.peer_port = 16'($urandom);
    it.now = $urandom;
    it.max_count = mc;
    return it;
  endfunction

  function automatic logic [127:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // an id at a chosen distance from own id, so buckets fill up near each other
  function automatic logic [127:0] id_in_bucket(int b);
    logic [127:0] d;
    d = rand_id();
    d = d >> b;
    d[127 - b] = 1'b1;
    return own_id ^ d;
  endfunction

  task automatic test_empty_and_own();
    send_op(make_op(FN_FIND, '0, 5'd4));
    send_op(make_op(FN_REMOVE, '1, 5'd0));
    send_op(make_op(FN_ADD, own_id, 5'd0));
    send_op(make_op(FN_UNDEF, '1, 5'd31));
    send_op(make_op(FN_ADD, '1, 5'd0));
    send_op(make_op(FN_FIND, '1, 5'd0));
    send_op(make_op(FN_FIND, '0, 5'd31));
  endtask

  task automatic test_full_bucket();
    logic [127:0] ids[$];
    for (int i = 0; i < DEPTH + 1; i++) begin
      ids = {ids, id_in_bucket(0)};
      send_op(make_op(FN_ADD, ids[i], 5'd0));
    end
    send_op(make_op(FN_ADD, ids[3], 5'd0));      // refresh
    send_op(make_op(FN_REMOVE, ids[2], 5'd0));
    send_op(make_op(FN_FIND, ids[0], 5'd16));
  endtask

  task automatic test_last_bucket();
    send_op(make_op(FN_ADD, own_id ^ 128'd1, 5'd0));
    send_op(make_op(FN_FIND, own_id, 5'd31));
  endtask

  // pauses the sender until every result has come
  task automatic test_drain_pause();
    wait_drained();
    send_op(make_op(FN_FIND, rand_id(), 5'd16));
  endtask

  task automatic test_random(int count);
    in_item_t it;
    logic [127:0] id;
    int sel;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 2 && n < count / 2 + 20);
      rx_idle_off = no_idle;
      sel = $urandom_range(99);
      if (known_ids.size() != 0 && sel < 30) id = known_ids[$urandom_range(known_ids.size()-1)];
      else if (sel < 85) id = id_in_bucket($urandom_range(7) == 0 ? 127 : $urandom_range(6));
      else id = rand_id();
      sel = $urandom_range(99);
      if (sel < 45) begin
        it = make_op(FN_ADD, id, 5'($urandom));
        known_ids = {known_ids, id};
      end else if (sel < 65) it = make_op(FN_REMOVE, id, 5'($urandom));
      else if (sel < 95) it = make_op(FN_FIND, id, 5'($urandom_range(31)));
      else it = make_op(FN_UNDEF, id, 5'($urandom));
      send_op(it);
    end
    no_idle = 1'b0;
    rx_idle_off = 1'b0;
  endtask

  initial begin
    own_id = '0;
    total = 0;
    foreach (fill[i]) fill[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_own();
    test_full_bucket();
    test_last_bucket();
    set_own_id('1);
    test_empty_and_own();
    test_drain_pause();
    set_own_id(rand_id());
    known_ids.delete();
    test_random(50);
    set_own_id(rand_id());
    known_ids.delete();
    test_random(50);
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
